// File: rtl/ramr_pkg.sv
// ramr_pkg: widths and item types for the rational add/multiply/reduce block
// standalone package, depends on nothing; used by rational_add_multiply_reduce
`default_nettype none

package ramr_pkg;

  // operand width of one numerator or denominator
  localparam int unsigned OPERAND_WIDTH = 16;
  // exact product width and magnitude width used by the gcd and dividers
  localparam int unsigned PROD_WIDTH    = 2 * OPERAND_WIDTH;
  localparam int unsigned NUM_WIDTH     = PROD_WIDTH + 1;
  localparam int unsigned DEN_WIDTH     = PROD_WIDTH - 1;
  localparam int unsigned CNT_WIDTH     = $clog2(PROD_WIDTH);

  localparam logic KIND_ADD = 1'b0;
  localparam logic KIND_MUL = 1'b1;

  typedef struct packed {
    logic                            kind;
    logic signed [OPERAND_WIDTH-1:0] left_numerator;
    logic signed [OPERAND_WIDTH-1:0] left_denominator;
    logic signed [OPERAND_WIDTH-1:0] right_numerator;
    logic signed [OPERAND_WIDTH-1:0] right_denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [NUM_WIDTH-1:0] result_numerator;
    logic        [DEN_WIDTH-1:0] result_denominator;
    logic                        bad_denominator;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/rational_add_multiply_reduce.sv
// rational_add_multiply_reduce: adds or multiplies two signed fractions and reduces the result
// depends on ramr_pkg for widths and item types
`default_nettype none

// usage
//   input item: in_data is taken at a rising edge where start is high and busy
//   is low. busy stays high while the item is worked on; no new item is taken
//   until it drops.
//   result item: out_data is valid for exactly one cycle, marked by out_valid.
//   the receiver cannot stall, so the item must be captured in that cycle.
//   result paths:
//     zero input denominator: result 0/1 with bad_denominator set, straight from idle
//     zero result numerator: result 0/1 after the multiply steps
//     general case: multiply, sign, factor-of-two strip, gcd, then both divisions
//   the gcd is binary (one compare/subtract or one shift per cycle, plus a swap
//   step when the larger value sits in the wrong register); both exact
//   divisions are restoring, one quotient bit per cycle. one multiplier serves
//   the multiply steps and one subtractor serves the gcd and both divisions.
//   busy drops in the cycle the strobe rises, so a new item may be taken then.
//   reset (rst_n low, synchronous) returns the sequencer to idle and drops the
//   strobe; an item in flight is lost.

module rational_add_multiply_reduce (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output      logic               busy,
  input  wire ramr_pkg::in_item_t in_data,
  output      logic               out_valid,
  output      ramr_pkg::out_item_t out_data
);

  localparam int unsigned OW = ramr_pkg::OPERAND_WIDTH;
  localparam int unsigned PW = ramr_pkg::PROD_WIDTH;
  localparam int unsigned NW = ramr_pkg::NUM_WIDTH;
  localparam int unsigned DW = ramr_pkg::DEN_WIDTH;
  localparam int unsigned CW = ramr_pkg::CNT_WIDTH;

  typedef enum logic [9:0] {
    S_IDLE = 10'b00_0000_0001,
    S_MUL0 = 10'b00_0000_0010,
    S_MUL1 = 10'b00_0000_0100,
    S_MUL2 = 10'b00_0000_1000,
    S_SIGN = 10'b00_0001_0000,
    S_TWOS = 10'b00_0010_0000,
    S_GCD  = 10'b00_0100_0000,
    S_DIVN = 10'b00_1000_0000,
    S_DIVD = 10'b01_0000_0000,
    S_HOLD = 10'b10_0000_0000
  } state_t;

  // control
  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // datapath
  ramr_pkg::in_item_t  op_r, op_nxt;
  ramr_pkg::out_item_t res_r, res_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [NW-1:0] num_r, num_nxt;
  logic                 neg_r, neg_nxt;
  logic [PW-1:0]        x_r, x_nxt;
  logic [PW-1:0]        y_r, y_nxt;
  logic [PW-1:0]        g_r, g_nxt;
  logic [PW-1:0]        rem_r, rem_nxt;
  logic [PW-1:0]        mnum_r, mnum_nxt;
  logic [PW-1:0]        mden_r, mden_nxt;
  logic [CW-1:0]        k_r, k_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;

  // shared multiplier
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] mul_p;

  // shared subtractor
  logic [PW:0]   sub_a, sub_b;
  logic [PW+1:0] sub_diff;
  logic          sub_borrow;

  // helpers
  logic [PW:0]   div_shift;
  logic [PW-1:0] div_quot;
  logic [PW-1:0] div_rem;
  logic [PW-1:0] mag_num, mag_den;
  logic [PW-1:0] gcd_base;
  logic [NW-1:0] num_abs_ext;
  logic          in_bad;
  logic          div_last;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = res_r;

  // multiplier operand selection, product lands in prod_r
  always_comb begin
    mul_a = op_r.left_numerator;
    mul_b = op_r.right_denominator;
    unique case (state_r)
      S_MUL0: begin
        mul_a = op_r.left_numerator;
        mul_b = (op_r.kind == ramr_pkg::KIND_MUL) ? op_r.right_numerator
                                                  : op_r.right_denominator;
      end
      S_MUL1: begin
        mul_a = op_r.right_numerator;
        mul_b = op_r.left_denominator;
      end
      S_MUL2: begin
        mul_a = op_r.left_denominator;
        mul_b = op_r.right_denominator;
      end
      default: begin
        mul_a = op_r.left_numerator;
        mul_b = op_r.right_denominator;
      end
    endcase
  end

  assign mul_p = PW'(mul_a) * PW'(mul_b);

  // subtractor: x - y during gcd, shifted remainder - g during division
  assign div_shift = {rem_r, x_r[PW-1]};

  always_comb begin
    if (state_r == S_GCD) begin
      sub_a = {1'b0, x_r};
      sub_b = {1'b0, y_r};
    end else begin
      sub_a = div_shift;
      sub_b = {1'b0, g_r};
    end
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[PW+1];

  assign div_quot = {x_r[PW-2:0], ~sub_borrow};
  assign div_rem  = sub_borrow ? div_shift[PW-1:0] : sub_diff[PW-1:0];
  assign div_last = (cnt_r == CW'(PW - 1));

  // magnitudes of the exact fraction
  assign mag_num = num_r[NW-1] ? PW'(-num_r) : num_r[PW-1:0];
  assign mag_den = prod_r[PW-1] ? PW'(-prod_r) : prod_r[PW-1:0];

  assign gcd_base    = (x_r == '0) ? y_r : x_r;
  assign num_abs_ext = {1'b0, mnum_r};

  assign in_bad = (in_data.left_denominator == '0) || (in_data.right_denominator == '0);

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    op_nxt        = op_r;
    res_nxt       = res_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    neg_nxt       = neg_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    g_nxt         = g_r;
    rem_nxt       = rem_r;
    mnum_nxt      = mnum_r;
    mden_nxt      = mden_r;
    k_nxt         = k_r;
    cnt_nxt       = cnt_r;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt = in_data;
          if (in_bad) begin
            // zero denominator: flag it and give 0/1 at once
            res_nxt.result_numerator   = '0;
            res_nxt.result_denominator = DW'(1);
            res_nxt.bad_denominator    = 1'b1;
            out_valid_nxt              = 1'b1;
          end else begin
            state_nxt = S_MUL0;
          end
        end
      end
      S_MUL0: begin
        prod_nxt  = mul_p;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        num_nxt   = {prod_r[PW-1], prod_r};
        prod_nxt  = mul_p;
        state_nxt = S_MUL2;
      end
      S_MUL2: begin
        // cross terms summed for add, second product dropped for multiply
        if (op_r.kind == ramr_pkg::KIND_ADD) begin
          num_nxt = num_r + {prod_r[PW-1], prod_r};
        end
        prod_nxt  = mul_p;
        state_nxt = S_SIGN;
      end
      S_SIGN: begin
        if (num_r == '0) begin
          res_nxt.result_numerator   = '0;
          res_nxt.result_denominator = DW'(1);
          res_nxt.bad_denominator    = 1'b0;
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end else begin
          neg_nxt   = num_r[NW-1] ^ prod_r[PW-1];
          x_nxt     = mag_num;
          y_nxt     = mag_den;
          mnum_nxt  = mag_num;
          mden_nxt  = mag_den;
          k_nxt     = '0;
          state_nxt = S_TWOS;
        end
      end
      S_TWOS: begin
        // strip common factors of two, counted in k
        if (!x_r[0] && !y_r[0]) begin
          x_nxt = x_r >> 1;
          y_nxt = y_r >> 1;
          k_nxt = k_r + CW'(1);
        end else begin
          state_nxt = S_GCD;
        end
      end
      S_GCD: begin
        priority if (x_r == '0 || y_r == '0) begin
          g_nxt     = gcd_base << k_r;
          x_nxt     = mnum_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIVN;
        end else if (!x_r[0]) begin
          x_nxt = x_r >> 1;
        end else if (!y_r[0]) begin
          y_nxt = y_r >> 1;
        end else if (sub_borrow) begin
          // both odd, x below y: swap so the next step subtracts
          x_nxt = y_r;
          y_nxt = x_r;
        end else begin
          x_nxt = sub_diff[PW-1:0];
        end
      end
      S_DIVN: begin
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + CW'(1);
        x_nxt   = div_quot;
        if (div_last) begin
          mnum_nxt  = div_quot;
          x_nxt     = mden_r;
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIVD;
        end
      end
      S_DIVD: begin
        rem_nxt = div_rem;
        cnt_nxt = cnt_r + CW'(1);
        x_nxt   = div_quot;
        if (div_last) begin
          res_nxt.result_numerator   = neg_r ? (NW'(0) - num_abs_ext) : num_abs_ext;
          res_nxt.result_denominator = div_quot[DW-1:0];
          res_nxt.bad_denominator    = 1'b0;
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      S_HOLD: begin
        // unused code, falls back to idle
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    res_r  <= res_nxt;
    prod_r <= prod_nxt;
    num_r  <= num_nxt;
    neg_r  <= neg_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    g_r    <= g_nxt;
    rem_r  <= rem_nxt;
    mnum_r <= mnum_nxt;
    mden_r <= mden_nxt;
    k_r    <= k_nxt;
    cnt_r  <= cnt_nxt;
  end

  // the divisor found by the gcd is never zero
  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVN || state_r == S_DIVD) |-> (g_r != '0))
    else $error("zero divisor during reduction");

  // a flagged item always reads 0/1
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.bad_denominator) |->
      (out_data.result_numerator == '0 && out_data.result_denominator == DW'(1)))
    else $error("flagged item is not 0/1");

  // an unflagged result comes only out of a busy sequence
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.bad_denominator) |-> $past(busy))
    else $error("result without work");

  // a valid item with nonzero denominators starts the sequencer
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_bad) |=> (busy && !out_valid))
    else $error("accepted item did not start");

  // reduced denominator is never zero
  a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.result_denominator != '0))
    else $error("zero result denominator");

endmodule

`default_nettype wire

// File: test/rational_add_multiply_reduce_tb.sv
// rational_add_multiply_reduce_tb: self-checking bench for the fraction add/multiply/reduce block
// drives operand pairs through the start/busy handshake and checks each strobed result against a
// typed-in answer or an in-bench fraction calculator; depends on ramr_pkg and the rtl top level
`timescale 1ns / 1ps

module rational_add_multiply_reduce_tb;

  localparam int unsigned NW = ramr_pkg::NUM_WIDTH;
  localparam int unsigned DW = ramr_pkg::DEN_WIDTH;

  typedef logic signed [ramr_pkg::OPERAND_WIDTH-1:0] operand_t;

  // one row of the directed table: the item, and a typed-in answer where one is given
  typedef struct {
    ramr_pkg::in_item_t  stim;
    bit                  typed;
    ramr_pkg::out_item_t answer;
  } fraction_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  ramr_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  ramr_pkg::out_item_t out_data;

  fraction_row_t       directed_rows[$];
  ramr_pkg::out_item_t expected_fractions[$];
  int                  fail_count = 0;

  rational_add_multiply_reduce dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // exact sum or product of the two fractions, put in lowest terms
  function automatic ramr_pkg::out_item_t predict_fraction(ramr_pkg::in_item_t it);
    longint              a, b, c, d, num, den;
    longint unsigned     mag_num, mag_den, x, y, r;
    bit                  neg;
    ramr_pkg::out_item_t res;
    a = longint'(it.left_numerator);
    b = longint'(it.left_denominator);
    c = longint'(it.right_numerator);
    d = longint'(it.right_denominator);
    res = '0;
    res.result_denominator = DW'(1);
    if (b == 0 || d == 0) begin
      res.bad_denominator = 1'b1;
      return res;
    end
    num = (it.kind == ramr_pkg::KIND_ADD) ? a * d + c * b : a * c;
    den = b * d;
    if (num == 0) return res;
    neg = (num < 0) != (den < 0);
    mag_num = (num < 0) ? -num : num;
    mag_den = (den < 0) ? -den : den;
    x = mag_num;
    y = mag_den;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    mag_num = mag_num / x;
    mag_den = mag_den / x;
    res.result_numerator = neg ? NW'(-longint'(mag_num)) : NW'(longint'(mag_num));
    res.result_denominator = DW'(mag_den);
    return res;
  endfunction

  function automatic void add_row(logic kind, operand_t a, operand_t b, operand_t c,
                                  operand_t d, bit typed,
                                  logic signed [NW-1:0] num,
                                  logic [DW-1:0] den, logic bad);
    fraction_row_t row;
    row.stim = '{kind, a, b, c, d};
    row.typed = typed;
    row.answer = '{num, den, bad};
    directed_rows.push_back(row);
  endfunction

  // some small values so the gcd has something to cancel, some extremes, over half full range
  function automatic operand_t pick_operand();
    operand_t v;
    int       sel;
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      case ($urandom_range(0, 4))
        0:       v = operand_t'(-32768);
        1:       v = operand_t'(32767);
        2:       v = operand_t'(-1);
        3:       v = '0;
        default: v = operand_t'(1);
      endcase
    end else if (sel < 45) begin
      v = operand_t'(int'($urandom_range(0, 40)) - 20);
    end else begin
      v = operand_t'($urandom);
    end
    return v;
  endfunction

  function automatic ramr_pkg::in_item_t random_fraction_pair();
    ramr_pkg::in_item_t it;
    int                 mode;
    it.kind = $urandom_range(0, 1) ? ramr_pkg::KIND_MUL : ramr_pkg::KIND_ADD;
    it.left_numerator = pick_operand();
    it.left_denominator = pick_operand();
    it.right_numerator = pick_operand();
    it.right_denominator = pick_operand();
    mode = $urandom_range(0, 99);
    if (mode < 4) begin
      it.left_denominator = '0;
    end else if (mode < 8) begin
      it.right_denominator = '0;
    end else if (mode < 10) begin
      it.left_denominator = '0;
      it.right_denominator = '0;
    end else if (mode < 16) begin
      // sums that cancel to zero, or a zero factor in a product
      if (it.kind == ramr_pkg::KIND_ADD) begin
        it.right_numerator = -it.left_numerator;
        it.right_denominator = it.left_denominator;
      end else begin
        it.left_numerator = '0;
      end
    end
    return it;
  endfunction

  // hold the item on the port until the block takes it, then record what it should give
  task automatic offer_item(ramr_pkg::in_item_t it, bit typed, ramr_pkg::out_item_t answer);
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy !== 1'b0);
    expected_fractions.push_back(typed ? answer : predict_fraction(it));
  endtask

  // random gap in the stream, long enough at times to land on any phase of the gcd or divides
  task automatic maybe_idle();
    int gap;
    if ($urandom_range(0, 99) < 9) begin
      gap = $urandom_range(1, 180);
      start <= 1'b0;
      in_data <= random_fraction_pair();
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_fractions.size() != 0) @(posedge clk);
  endtask

  // results cannot be held off, so every strobe is checked at the edge that ends it
  always @(posedge clk) begin
    ramr_pkg::out_item_t want;
    if (out_valid) begin
      if (expected_fractions.size() == 0) begin
        $error("result with nothing expected: %0d/%0d bad %0b",
               out_data.result_numerator, out_data.result_denominator,
               out_data.bad_denominator);
        fail_count++;
      end else begin
        want = expected_fractions.pop_front();
        if (out_data.result_numerator !== want.result_numerator) begin
          $error("result_numerator: expected %0d, got %0d",
                 want.result_numerator, out_data.result_numerator);
          fail_count++;
        end
        if (out_data.result_denominator !== want.result_denominator) begin
          $error("result_denominator: expected %0d, got %0d",
                 want.result_denominator, out_data.result_denominator);
          fail_count++;
        end
        if (out_data.bad_denominator !== want.bad_denominator) begin
          $error("bad_denominator: expected %0b, got %0b",
                 want.bad_denominator, out_data.bad_denominator);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int                 n;
    ramr_pkg::in_item_t item;

    // zero denominators give 0/1 with the flag, whatever else is on the operands
    add_row(ramr_pkg::KIND_ADD, 1, 0, 1, 1, 1, 0, 1, 1);
    add_row(ramr_pkg::KIND_MUL, 1, 1, 5, 0, 1, 0, 1, 1);
    add_row(ramr_pkg::KIND_ADD, 0, 0, 0, 0, 1, 0, 1, 1);
    add_row(ramr_pkg::KIND_MUL, 32767, 0, -32768, 0, 1, 0, 1, 1);
    add_row(ramr_pkg::KIND_ADD, -32768, 7, 32767, 0, 1, 0, 1, 1);
    // zero numerators come out as 0/1 without the flag
    add_row(ramr_pkg::KIND_MUL, 0, 5, 7, 3, 1, 0, 1, 0);
    add_row(ramr_pkg::KIND_ADD, 3, 4, -3, 4, 1, 0, 1, 0);
    add_row(ramr_pkg::KIND_ADD, 0, -32768, 0, 1, 1, 0, 1, 0);
    // most negative and most positive operands, exact at full width, and two small cases
    add_row(ramr_pkg::KIND_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1, 0);
    add_row(ramr_pkg::KIND_ADD, -32768, 1, -32768, 1, 1, -65536, 1, 0);
    add_row(ramr_pkg::KIND_MUL, 32767, 1, 32767, 1, 1, 1073676289, 1, 0);
    add_row(ramr_pkg::KIND_MUL, 1, -32768, 1, -32768, 1, 1, 1073741824, 0);
    add_row(ramr_pkg::KIND_ADD, 7, 1, 0, 1, 1, 7, 1, 0);
    add_row(ramr_pkg::KIND_MUL, -1, -1, -1, -1, 1, 1, 1, 0);
    // the rest go through the calculator
    add_row(ramr_pkg::KIND_ADD, 1, 32767, 1, -32768, 0, 0, 0, 0);
    add_row(ramr_pkg::KIND_MUL, -32768, -1, 32767, -1, 0, 0, 0, 0);
    add_row(ramr_pkg::KIND_ADD, -32768, -32768, -32768, -32767, 0, 0, 0, 0);
    add_row(ramr_pkg::KIND_ADD, 32767, 32767, -32768, -32768, 0, 0, 0, 0);
    add_row(ramr_pkg::KIND_ADD, 6, 4, 10, -8, 0, 0, 0, 0);
    add_row(ramr_pkg::KIND_MUL, 2, -3, 3, 4, 0, 0, 0, 0);
    add_row(ramr_pkg::KIND_ADD, 32767, -32767, 32767, -32768, 0, 0, 0, 0);
    add_row(ramr_pkg::KIND_MUL, -32768, 32767, -32768, 32767, 0, 0, 0, 0);
    add_row(ramr_pkg::KIND_ADD, 12345, -6789, -321, 4096, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      offer_item(directed_rows[k].stim, directed_rows[k].typed, directed_rows[k].answer);
      maybe_idle();
    end
    drain_results();

    // random part, with a stretch of back-to-back items and a few full drains
    n = 1680;
    for (int k = 0; k < n; k++) begin
      item = random_fraction_pair();
      offer_item(item, 1'b0, '0);
      if (k % 400 == 399) drain_results();
      else if (k < 600 || k >= 1000) maybe_idle();
    end

    drain_results();
    // long enough past the slowest item that anything stray shows up well inside this wait
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // generous watchdog: a few times the slowest legal run of all items and gaps
  initial begin
    #30_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: rational_add_multiply_reduce.f
rtl/ramr_pkg.sv
rtl/rational_add_multiply_reduce.sv
test/rational_add_multiply_reduce_tb.sv
